### sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg: shared types and constants for the HSV to RGB converter
// Pixel structs, fixed-point formats, sector codes and the hue reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    // Unit fractions: 12 fraction bits, 4096 = 1.0, 13 bits to hold 1.0
    localparam int UNIT_BITS = 12;
    localparam int UNIT_W    = UNIT_BITS + 1;
    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << UNIT_BITS;

    // Hue: degrees times 64
    localparam int HUE_W       = 15;
    localparam int SECTOR_SPAN = 3840;
    localparam int SECTOR_MAX  = 8;     // largest raw sector a 15-bit hue reaches
    localparam int RAW_SEC_W   = 4;
    localparam int REM_W       = 12;    // hue mod 3840 stays below 4096

    // Sector fraction f, FRAC_BITS fraction bits (8 to 16)
    localparam int FRAC_BITS = 12;
    localparam logic [FRAC_BITS:0] F_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // f = floor(rem * 2^FRAC_BITS / 3840) = (rem * RECIP) >> RECIP_SHIFT.
    // The rounded-up reciprocal errs by less than 1/3840 over the rem range.
    localparam int      RECIP_SHIFT = 24;
    localparam int      RECIP_W     = FRAC_BITS + 13;
    localparam longint  RECIP_L     =
        ((longint'(1) << (FRAC_BITS + RECIP_SHIFT)) + SECTOR_SPAN - 1) / SECTOR_SPAN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int      FPROD_W     = REM_W + RECIP_W;

    // Sixty-degree sectors of the color wheel
    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [UNIT_W-1:0] saturation;
        logic [UNIT_W-1:0] brightness;
    } t_hsv_pixel;

    typedef struct packed {
        logic [UNIT_W-1:0] red;
        logic [UNIT_W-1:0] green;
        logic [UNIT_W-1:0] blue;
    } t_rgb_pixel;

endpackage

`default_nettype wire

### sv/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsv2rgb_scale: value times one-minus-k
// Forms floor(v * (1.0 - k)) in 12-bit unit fractions, k no larger than 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_scale (
    input  wire logic [hsv2rgb_pkg::UNIT_W-1:0] i_val,
    input  wire logic [hsv2rgb_pkg::UNIT_W-1:0] i_k,
    output logic      [hsv2rgb_pkg::UNIT_W-1:0] o_res
);

    logic [hsv2rgb_pkg::UNIT_W-1:0]   one_minus_k;
    logic [2*hsv2rgb_pkg::UNIT_W-1:0] prod;

    assign one_minus_k = hsv2rgb_pkg::UNIT_ONE - i_k;
    assign prod        = i_val * one_minus_k;
    // Drop the fraction bits (floor)
    assign o_res = prod[hsv2rgb_pkg::UNIT_BITS +: hsv2rgb_pkg::UNIT_W];

endmodule

`default_nettype wire

### sv/hsv_to_rgb_convert.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert: streaming HSV to RGB pixel converter
// Five-stage pipeline turning hue/saturation/value into red/green/blue.
// ----------------------------------------------------------------------------
//
//  Channel  | Valid        | Ready        | Payload                | Dir
//  ---------+--------------+--------------+------------------------+-----
//  pixel in | i_in_valid   | o_in_ready   | i_in_data  (HSV)       | in
//  pixel out| o_out_valid  | i_out_ready  | o_out_data (RGB)       | out
//
// Throughput is one pixel per cycle when the output is not stalled.
// Stages: sector split, f and p, s*f products, q and t products,
// sector routing into the output register.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// A stall at the output backs up stage by stage: a stage advances when it
// is empty or the stage after it advances, so bubbles are squeezed out and
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_convert (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire hsv2rgb_pkg::t_hsv_pixel i_in_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output hsv2rgb_pkg::t_rgb_pixel      o_out_data
);

    localparam int UW = hsv2rgb_pkg::UNIT_W;
    localparam int FB = hsv2rgb_pkg::FRAC_BITS;

    // ------------------------------------------------------------------
    // Stage valid bits and advance chain
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !r_out_valid || i_out_ready;
    assign adv4 = !r_s4_valid  || adv5;
    assign adv3 = !r_s3_valid  || adv4;
    assign adv2 = !r_s2_valid  || adv3;
    assign adv1 = !r_s1_valid  || adv2;

    assign o_in_ready  = adv1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv1) r_s1_valid  <= i_in_valid;
            if (adv2) r_s2_valid  <= r_s1_valid;
            if (adv3) r_s3_valid  <= r_s2_valid;
            if (adv4) r_s4_valid  <= r_s3_valid;
            if (adv5) r_out_valid <= r_s4_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp s and v, split hue into sector and remainder
    // ------------------------------------------------------------------
    logic [UW-1:0]                          sat_clamp, val_clamp;
    logic [hsv2rgb_pkg::RAW_SEC_W-1:0]      raw_sector;
    logic [hsv2rgb_pkg::HUE_W-1:0]          sector_base;
    logic [hsv2rgb_pkg::HUE_W-1:0]          hue_rem;
    hsv2rgb_pkg::t_sector                   sector_wrap;

    assign sat_clamp = (i_in_data.saturation > hsv2rgb_pkg::UNIT_ONE) ?
                       hsv2rgb_pkg::UNIT_ONE : i_in_data.saturation;
    assign val_clamp = (i_in_data.brightness > hsv2rgb_pkg::UNIT_ONE) ?
                       hsv2rgb_pkg::UNIT_ONE : i_in_data.brightness;

    // Independent threshold compares; the highest one passed wins
    always_comb begin
        raw_sector  = '0;
        sector_base = '0;
        for (int k = 1; k <= hsv2rgb_pkg::SECTOR_MAX; k++) begin
            if (i_in_data.hue >= hsv2rgb_pkg::HUE_W'(k * hsv2rgb_pkg::SECTOR_SPAN)) begin
                raw_sector  = hsv2rgb_pkg::RAW_SEC_W'(k);
                sector_base = hsv2rgb_pkg::HUE_W'(k * hsv2rgb_pkg::SECTOR_SPAN);
            end
        end
    end

    assign hue_rem = i_in_data.hue - sector_base;

    // 360 degrees and above wrap around the wheel once
    always_comb begin
        if (raw_sector >= hsv2rgb_pkg::RAW_SEC_W'(6)) begin
            sector_wrap = hsv2rgb_pkg::t_sector'(3'(raw_sector - hsv2rgb_pkg::RAW_SEC_W'(6)));
        end else begin
            sector_wrap = hsv2rgb_pkg::t_sector'(raw_sector[2:0]);
        end
    end

    logic [UW-1:0]                  r_s1_sat, r_s1_val;
    logic [hsv2rgb_pkg::REM_W-1:0]  r_s1_rem;
    hsv2rgb_pkg::t_sector           r_s1_sector;
    logic                           r_s1_grey;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_sat    <= sat_clamp;
            r_s1_val    <= val_clamp;
            r_s1_rem    <= hue_rem[hsv2rgb_pkg::REM_W-1:0];
            r_s1_sector <= sector_wrap;
            r_s1_grey   <= (sat_clamp == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: f from remainder by reciprocal multiply; p = v(1-s)
    // ------------------------------------------------------------------
    logic [hsv2rgb_pkg::FPROD_W-1:0] f_prod;
    logic [UW-1:0]                   pv;

    assign f_prod = r_s1_rem * hsv2rgb_pkg::RECIP;

    hsv2rgb_scale u_scale_p (
        .i_val (r_s1_val),
        .i_k   (r_s1_sat),
        .o_res (pv)
    );

    logic [FB-1:0]          r_s2_f;
    logic [UW-1:0]          r_s2_sat, r_s2_val, r_s2_pv;
    hsv2rgb_pkg::t_sector   r_s2_sector;
    logic                   r_s2_grey;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_f      <= f_prod[hsv2rgb_pkg::RECIP_SHIFT +: FB];
            r_s2_sat    <= r_s1_sat;
            r_s2_val    <= r_s1_val;
            r_s2_pv     <= pv;
            r_s2_sector <= r_s1_sector;
            r_s2_grey   <= r_s1_grey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: s*f and s*(1-f), truncated to unit fractions
    // ------------------------------------------------------------------
    logic [FB:0]        f_comp;
    logic [UW+FB-1:0]   sf_prod;
    logic [UW+FB:0]     sg_prod;

    assign f_comp  = hsv2rgb_pkg::F_ONE - {1'b0, r_s2_f};
    assign sf_prod = r_s2_sat * r_s2_f;
    assign sg_prod = r_s2_sat * f_comp;

    logic [UW-1:0]          r_s3_sf, r_s3_sg, r_s3_val, r_s3_pv;
    hsv2rgb_pkg::t_sector   r_s3_sector;
    logic                   r_s3_grey;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_sf     <= sf_prod[FB +: UW];
            r_s3_sg     <= sg_prod[FB +: UW];     // never above s, fits a unit
            r_s3_val    <= r_s2_val;
            r_s3_pv     <= r_s2_pv;
            r_s3_sector <= r_s2_sector;
            r_s3_grey   <= r_s2_grey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: q = v(1-sf), t = v(1-s(1-f))
    // ------------------------------------------------------------------
    logic [UW-1:0] qv, tv;

    hsv2rgb_scale u_scale_q (
        .i_val (r_s3_val),
        .i_k   (r_s3_sf),
        .o_res (qv)
    );

    hsv2rgb_scale u_scale_t (
        .i_val (r_s3_val),
        .i_k   (r_s3_sg),
        .o_res (tv)
    );

    logic [UW-1:0]          r_s4_qv, r_s4_tv, r_s4_val, r_s4_pv;
    hsv2rgb_pkg::t_sector   r_s4_sector;
    logic                   r_s4_grey;

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_s4_qv     <= qv;
            r_s4_tv     <= tv;
            r_s4_val    <= r_s3_val;
            r_s4_pv     <= r_s3_pv;
            r_s4_sector <= r_s3_sector;
            r_s4_grey   <= r_s3_grey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: route v, p, q, t by sector; grey passes v to all three
    // ------------------------------------------------------------------
    hsv2rgb_pkg::t_rgb_pixel rgb_sel;

    always_comb begin
        rgb_sel = '{red: r_s4_val, green: r_s4_val, blue: r_s4_val};
        if (!r_s4_grey) begin
            unique case (r_s4_sector)
                hsv2rgb_pkg::SEC_RED_YELLOW:
                    rgb_sel = '{red: r_s4_val, green: r_s4_tv,  blue: r_s4_pv};
                hsv2rgb_pkg::SEC_YELLOW_GREEN:
                    rgb_sel = '{red: r_s4_qv,  green: r_s4_val, blue: r_s4_pv};
                hsv2rgb_pkg::SEC_GREEN_CYAN:
                    rgb_sel = '{red: r_s4_pv,  green: r_s4_val, blue: r_s4_tv};
                hsv2rgb_pkg::SEC_CYAN_BLUE:
                    rgb_sel = '{red: r_s4_pv,  green: r_s4_qv,  blue: r_s4_val};
                hsv2rgb_pkg::SEC_BLUE_MAGENTA:
                    rgb_sel = '{red: r_s4_tv,  green: r_s4_pv,  blue: r_s4_val};
                default:
                    rgb_sel = '{red: r_s4_val, green: r_s4_pv,  blue: r_s4_qv};
            endcase
        end
    end

    hsv2rgb_pkg::t_rgb_pixel r_out_data;

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_out_data <= rgb_sel;
        end
    end

    assign o_out_data = r_out_data;

endmodule

`default_nettype wire
